@@ rtl/abst_pkg.sv @@
package abst_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Result events
  localparam logic [1:0] EV_BIT   = 2'd0;
  localparam logic [1:0] EV_BYTE  = 2'd1;
  localparam logic [1:0] EV_MSG   = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 2'd2;

  localparam logic [15:0] TIMEOUT_RST    = 16'd100;
  localparam logic [7:0]  RETRY_LIM_RST  = 8'd10;
  localparam logic [7:0]  TERMINATOR_RST = 8'd4;

  localparam logic [7:0]  RETRY_MAX = 8'hFF;
  localparam logic [2:0]  LAST_BIT  = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       bit_value;
    logic       is_retry;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  retry_limit;
    logic [7:0]  terminator_code;
  } cfg_t;

  // Transmitter state apart from the wait timer, whose width is a parameter
  typedef struct packed {
    logic [7:0] shift_byte;
    logic [2:0] bit_pos;
    logic [7:0] retry_cnt;
    logic       busy;
    logic       term_pending;
    logic       sending_term;
  } tx_state_t;

endpackage

@@ rtl/ack_bit_serial_transmitter.sv @@
// Stop-and-wait bit-serial transmitter.
// Input channel (in_valid_i / in_stall_o / in_item_i): one beat per item.
//   A byte beat starts a byte when idle and is dropped when busy; an
//   acknowledge beat advances to the next bit; a tick beat counts toward the
//   timeout, then the bit is resent as a retry or, past the retry limit, fails.
// Output channel (out_valid_o / out_stall_i / out_item_o): zero or one beat
//   per input item - a bit symbol, byte done, message done or retry error.
// Each accepted item waits in the input register until the result slot frees;
//   its result, if any, is then captured in the result register.
// Throughput: one item per cycle while out_stall_i is low; the state update
//   is a single pass through abst_step between the input and result registers.
// When the receiver stalls, the result register holds its beat and the input
//   register holds one more item; beyond that in_stall_o rises.
// Reset (rst_ni low, asynchronous) empties both registers, returns the
//   block to idle and loads the register defaults: timeout 100 ticks, retry
//   limit 10, terminator byte 4. Write configuration only while idle.
module ack_bit_serial_transmitter #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  abst_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output abst_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [abst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [abst_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import abst_pkg::*;

  cfg_t                  cfg_q;
  tx_state_t             st_q, st_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;

  logic                  in_vld_q;
  in_item_t              in_item_q;
  logic                  out_vld_q;
  out_item_t             out_item_q;

  logic                  res_vld;
  out_item_t             res;
  logic                  slot_free;
  logic                  advance;
  logic                  in_take;

  // The result slot frees when empty or when its beat leaves this cycle
  assign slot_free  = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && slot_free;
  assign in_stall_o = in_vld_q && !slot_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{timeout_ticks: TIMEOUT_RST, retry_limit: RETRY_LIM_RST,
                 terminator_code: TERMINATOR_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT:    cfg_q.timeout_ticks   <= cfg_data_i;
        CFG_RETRY_LIM:  cfg_q.retry_limit     <= cfg_data_i[7:0];
        CFG_TERMINATOR: cfg_q.terminator_code <= cfg_data_i[7:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Input register: hold the beat until the result slot can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
  end

  abst_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cur_i     (st_q),
    .timer_i   (timer_q),
    .cfg_i     (cfg_q),
    .item_i    (in_item_q),
    .nxt_o     (st_d),
    .timer_o   (timer_d),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Transmitter state advances once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      timer_q <= '0;
    end else if (advance) begin
      st_q    <= st_d;
      timer_q <= timer_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/abst_step.sv @@
module abst_step #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  abst_pkg::tx_state_t      cur_i,
  input  logic [TIMER_BITS-1:0]    timer_i,
  input  abst_pkg::cfg_t           cfg_i,
  input  abst_pkg::in_item_t       item_i,
  output abst_pkg::tx_state_t      nxt_o,
  output logic [TIMER_BITS-1:0]    timer_o,
  output logic                     res_vld_o,
  output abst_pkg::out_item_t      res_o
);
  import abst_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [TIMER_BITS-1:0] timer_inc;
  logic                  timeout_hit;
  logic [2:0]            nxt_pos;

  // Saturating tick count; fire at the timeout or when the timer tops out
  assign timer_inc   = (&timer_i) ? timer_i : timer_i + TIMER_BITS'(1);
  assign timeout_hit = (CMP_W'(timer_inc) >= CMP_W'(cfg_i.timeout_ticks)) || (&timer_inc);
  assign nxt_pos     = cur_i.bit_pos + 3'd1;

  always_comb begin
    nxt_o     = cur_i;
    timer_o   = timer_i;
    res_vld_o = 1'b0;
    res_o     = '{event_res: EV_BIT, bit_value: 1'b0, is_retry: 1'b0};
    unique case (item_i.kind)
      KIND_BYTE: begin
        if (!cur_i.busy) begin
          nxt_o.shift_byte   = item_i.data_byte;
          nxt_o.bit_pos      = '0;
          nxt_o.retry_cnt    = '0;
          nxt_o.busy         = 1'b1;
          nxt_o.term_pending = item_i.last_byte;
          nxt_o.sending_term = 1'b0;
          timer_o            = '0;
          res_vld_o          = 1'b1;
          res_o.bit_value    = item_i.data_byte[0];
        end
      end
      KIND_ACK: begin
        if (cur_i.busy) begin
          res_vld_o = 1'b1;
          priority if (cur_i.bit_pos != LAST_BIT) begin
            nxt_o.bit_pos   = nxt_pos;
            timer_o         = '0;
            res_o.bit_value = cur_i.shift_byte[nxt_pos];
          end else if (cur_i.sending_term) begin
            nxt_o.busy         = 1'b0;
            nxt_o.sending_term = 1'b0;
            nxt_o.term_pending = 1'b0;
            res_o.event_res    = EV_MSG;
          end else if (cur_i.term_pending) begin
            // chain the terminator byte with a fresh retry budget
            nxt_o.term_pending = 1'b0;
            nxt_o.sending_term = 1'b1;
            nxt_o.shift_byte   = cfg_i.terminator_code;
            nxt_o.bit_pos      = '0;
            nxt_o.retry_cnt    = '0;
            timer_o            = '0;
            res_o.bit_value    = cfg_i.terminator_code[0];
          end else begin
            nxt_o.busy      = 1'b0;
            timer_o         = '0;
            res_o.event_res = EV_BYTE;
          end
        end
      end
      KIND_TICK: begin
        if (cur_i.busy) begin
          if (!timeout_hit) begin
            timer_o = timer_inc;
          end else begin
            timer_o   = '0;
            res_vld_o = 1'b1;
            if (cur_i.retry_cnt > cfg_i.retry_limit) begin
              nxt_o.busy         = 1'b0;
              nxt_o.term_pending = 1'b0;
              nxt_o.sending_term = 1'b0;
              res_o.event_res    = EV_ERROR;
            end else begin
              if (cur_i.retry_cnt != RETRY_MAX) begin
                nxt_o.retry_cnt = cur_i.retry_cnt + 8'd1;
              end
              res_o.bit_value = cur_i.shift_byte[cur_i.bit_pos];
              res_o.is_retry  = 1'b1;
            end
          end
        end
      end
      default: begin
        // unused kind: drop
      end
    endcase
  end

endmodule

@@ rtl/abst_checker.sv @@
module abst_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input abst_pkg::out_item_t   out_item_o
);
  import abst_pkg::*;

  // Stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  // Stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result payload changed under stall");

  // Only bit symbols carry a bit value or a retry mark
  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.event_res != EV_BIT)
      |-> !out_item_o.bit_value && !out_item_o.is_retry)
    else $error("non-bit event carries bit fields");

  // A fresh result follows an input beat taken earlier through the input register
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching input beat");

endmodule

bind ack_bit_serial_transmitter abst_checker u_abst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
